>>> src/wbcd_pkg.sv
// ----------------------------------------------------------------------------
// wbcd_pkg - shared types and constants of the weighted BCD codec
// Register indexes, digit limits and the greedy digit code builder.
// ----------------------------------------------------------------------------
package wbcd_pkg;

    localparam int unsigned MAX_DIGITS = 4;
    localparam int unsigned NUM_CODES  = 10;

    localparam logic [2:0] REG_WEIGHT_MSB    = 3'd0;
    localparam logic [2:0] REG_WEIGHT_SECOND = 3'd1;
    localparam logic [2:0] REG_WEIGHT_THIRD  = 3'd2;
    localparam logic [2:0] REG_WEIGHT_LSB    = 3'd3;
    localparam logic [2:0] REG_DIGIT_COUNT   = 3'd4;

    localparam logic [3:0] RST_WEIGHT_MSB    = 4'd8;
    localparam logic [3:0] RST_WEIGHT_SECOND = 4'd4;
    localparam logic [3:0] RST_WEIGHT_THIRD  = 4'd2;
    localparam logic [3:0] RST_WEIGHT_LSB    = 4'd1;
    localparam logic [2:0] RST_DIGIT_COUNT   = 3'd3;

    // reciprocal of ten, exact for any 16-bit dividend after >> DIV10_SHIFT
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int unsigned DIV10_SHIFT = 19;
    // reciprocal of ten for the small top quotient (below 128)
    localparam logic [7:0]  DIV10_SMALL_MUL   = 8'd205;
    localparam int unsigned DIV10_SMALL_SHIFT = 11;

    localparam logic [15:0] POW10 [MAX_DIGITS] = '{16'd1, 16'd10, 16'd100, 16'd1000};

    typedef logic [3:0] nibble_t;
    typedef logic [5:0] dsum_t;

    // Greedy code: try weights from bit 3 down, take while remainder allows.
    function automatic nibble_t digit_code(input logic [3:0] digit,
                                           input logic [3:0] w3,
                                           input logic [3:0] w2,
                                           input logic [3:0] w1,
                                           input logic [3:0] w0);
        logic [3:0] rem;
        nibble_t    code;
        rem  = digit;
        code = '0;
        if (rem >= w3)
        begin
            rem     = rem - w3;
            code[3] = 1'b1;
        end
        if (rem >= w2)
        begin
            rem     = rem - w2;
            code[2] = 1'b1;
        end
        if (rem >= w1)
        begin
            rem     = rem - w1;
            code[1] = 1'b1;
        end
        if (rem >= w0)
        begin
            code[0] = 1'b1;
        end
        return code;
    endfunction

endpackage

>>> src/weighted_bcd_codec_top.sv
// ----------------------------------------------------------------------------
// weighted_bcd_codec_top - binary <-> weighted BCD converter
// Encodes a binary value into packed weighted digit codes, or decodes
// packed codes back to binary, with configurable bit weights.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_*: s_tuser selects the command (0 encode,
//   1 decode), s_tdata carries the operand. Each input beat yields exactly
//   one output beat on m_*: m_tdata is the result, m_tuser the decode error.
//   The configuration port writes one register per cycle with cfg_wen high
//   (index 0..3 weights of code bits 3..0, index 4 digit count); write it
//   only while no beat is in flight.
//   Throughput: one beat per cycle unless the output stalls, set by a
//   six-register pipeline (input register, three divide-by-ten stages, one
//   digit stage, output register); every stage shifts together.
//   Reset clears all stage valid bits and loads the 8421 weights with a
//   digit count of three. When m_tready is low while a result waits, the
//   whole pipeline holds and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module weighted_bcd_codec_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] operand
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] result
    output logic        m_tuser,   // [0] error
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import wbcd_pkg::*;

    // configuration
    logic [3:0] w_msb_reg, w_second_reg, w_third_reg, w_lsb_reg;
    logic [2:0] digit_count_reg;
    nibble_t    code_tab_reg  [NUM_CODES];
    nibble_t    code_tab_next [NUM_CODES];
    logic [2:0] nact;

    // pipeline control
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;

    // stage 1: input register
    logic        s1_cmd_reg;
    logic [15:0] s1_opnd_reg;

    // stage 2: first quotient, decode digit sums
    logic        s2_cmd_reg;
    logic [15:0] s2_opnd_reg;
    logic [12:0] s2_q1_reg;
    dsum_t       s2_dsum_reg [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] s2_hit_reg;
    dsum_t       s2_dsum_next [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] s2_hit_next;

    // stage 3: digit 0, second quotient, weighted decode terms
    logic        s3_cmd_reg;
    logic [3:0]  s3_d0_reg;
    logic [12:0] s3_q1_reg;
    logic [9:0]  s3_q2_reg;
    logic [15:0] s3_term_reg [MAX_DIGITS];
    logic        s3_err_reg;
    logic [15:0] s3_term_next [MAX_DIGITS];
    logic        s3_err_next;

    // stage 4: digit 1, third quotient, decode sum
    logic        s4_cmd_reg;
    logic [3:0]  s4_d0_reg, s4_d1_reg;
    logic [9:0]  s4_q2_reg;
    logic [6:0]  s4_q3_reg;
    logic [15:0] s4_sum_reg;
    logic        s4_err_reg;

    // stage 5: digits 2 and 3
    logic        s5_cmd_reg;
    nibble_t     s5_dig_reg [MAX_DIGITS];
    logic [15:0] s5_sum_reg;
    logic        s5_err_reg;
    logic [3:0]  s5_d3_next;

    // output register
    logic [15:0] out_result_reg, out_result_next;
    logic        out_error_reg, out_error_next;

    // ------------------------------------------------------------------
    // configuration registers and code table
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < NUM_CODES; j++)
        begin
            code_tab_next[j] = digit_code(4'(j), w_msb_reg, w_second_reg,
                                          w_third_reg, w_lsb_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_msb_reg       <= RST_WEIGHT_MSB;
            w_second_reg    <= RST_WEIGHT_SECOND;
            w_third_reg     <= RST_WEIGHT_THIRD;
            w_lsb_reg       <= RST_WEIGHT_LSB;
            digit_count_reg <= RST_DIGIT_COUNT;
            for (int j = 0; j < NUM_CODES; j++)
            begin
                code_tab_reg[j] <= 4'(j);
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    REG_WEIGHT_MSB:    w_msb_reg       <= cfg_wdata;
                    REG_WEIGHT_SECOND: w_second_reg    <= cfg_wdata;
                    REG_WEIGHT_THIRD:  w_third_reg     <= cfg_wdata;
                    REG_WEIGHT_LSB:    w_lsb_reg       <= cfg_wdata;
                    REG_DIGIT_COUNT:   digit_count_reg <= cfg_wdata[2:0];
                    default:           ;
                endcase
            end
            for (int j = 0; j < NUM_CODES; j++)
            begin
                code_tab_reg[j] <= code_tab_next[j];
            end
        end
    end

    assign nact = (digit_count_reg > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : digit_count_reg;

    // ------------------------------------------------------------------
    // pipeline control: every stage shifts while the output is free
    // ------------------------------------------------------------------
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // datapath logic
    // ------------------------------------------------------------------
    // decode: per nibble, add every digit whose code matches
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            s2_dsum_next[i] = '0;
            s2_hit_next[i]  = 1'b0;
            for (int j = 0; j < NUM_CODES; j++)
            begin
                if (code_tab_reg[j] == s1_opnd_reg[4*i +: 4])
                begin
                    s2_dsum_next[i] = s2_dsum_next[i] + 6'(j);
                    s2_hit_next[i]  = 1'b1;
                end
            end
        end
    end

    // decode: scale each digit sum, flag unmatched active nibbles, drop nibbles beyond the digit count
    always_comb
    begin
        s3_err_next = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (3'(i) < nact)
            begin
                s3_term_next[i] = 16'(s2_dsum_reg[i]) * POW10[i];
                if (!s2_hit_reg[i])
                begin
                    s3_err_next = 1'b1;
                end
            end
            else
            begin
                s3_term_next[i] = '0;
            end
        end
    end

    // top digit of the small quotient
    always_comb
    begin
        logic [14:0] prod;
        logic [2:0]  q4;
        prod       = 15'(s4_q3_reg) * 15'(DIV10_SMALL_MUL);
        q4         = prod[DIV10_SMALL_SHIFT +: 3];
        s5_d3_next = 4'(s4_q3_reg - 7'(q4) * 7'd10);
    end

    // output: decode passes the sum (zero on error); encode packs codes of active digits, upper nibbles zero
    always_comb
    begin
        out_result_next = '0;
        out_error_next  = 1'b0;
        if (s5_cmd_reg)
        begin
            out_result_next = s5_err_reg ? 16'd0 : s5_sum_reg;
            out_error_next  = s5_err_reg;
        end
        else
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                for (int j = 0; j < NUM_CODES; j++)
                begin
                    if (3'(i) < nact && s5_dig_reg[i] == 4'(j))
                    begin
                        out_result_next[4*i +: 4] = code_tab_reg[j];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_cmd_reg  <= s_tuser;
            s1_opnd_reg <= s_tdata;

            // stage 2
            s2_cmd_reg  <= s1_cmd_reg;
            s2_opnd_reg <= s1_opnd_reg;
            s2_q1_reg   <= 13'((32'(s1_opnd_reg) * 32'(DIV10_MUL)) >> DIV10_SHIFT);
            s2_hit_reg  <= s2_hit_next;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                s2_dsum_reg[i] <= s2_dsum_next[i];
            end

            // stage 3
            s3_cmd_reg <= s2_cmd_reg;
            s3_d0_reg  <= 4'(s2_opnd_reg - 16'(s2_q1_reg) * 16'd10);
            s3_q1_reg  <= s2_q1_reg;
            s3_q2_reg  <= 10'((29'(s2_q1_reg) * 29'(DIV10_MUL)) >> DIV10_SHIFT);
            s3_err_reg <= s3_err_next;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                s3_term_reg[i] <= s3_term_next[i];
            end

            // stage 4
            s4_cmd_reg <= s3_cmd_reg;
            s4_d0_reg  <= s3_d0_reg;
            s4_d1_reg  <= 4'(s3_q1_reg - 13'(s3_q2_reg) * 13'd10);
            s4_q2_reg  <= s3_q2_reg;
            s4_q3_reg  <= 7'((26'(s3_q2_reg) * 26'(DIV10_MUL)) >> DIV10_SHIFT);
            s4_sum_reg <= 16'(s3_term_reg[0] + s3_term_reg[1]
                              + s3_term_reg[2] + s3_term_reg[3]);
            s4_err_reg <= s3_err_reg;

            // stage 5
            s5_cmd_reg    <= s4_cmd_reg;
            s5_dig_reg[0] <= s4_d0_reg;
            s5_dig_reg[1] <= s4_d1_reg;
            s5_dig_reg[2] <= 4'(s4_q2_reg - 10'(s4_q3_reg) * 10'd10);
            s5_dig_reg[3] <= s5_d3_next;
            s5_sum_reg    <= s4_sum_reg;
            s5_err_reg    <= s4_err_reg;

            // output
            out_result_reg <= out_result_next;
            out_error_reg  <= out_error_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;
    assign m_tuser  = out_error_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("decode error with nonzero result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted beat missing from first stage");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(v5_reg) && m_tvalid)
        else $error("pipeline moved during stall");

endmodule

>>> tb/tb_weighted_bcd_codec_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_bcd_codec_top - self-checking bench for the weighted BCD codec
// Runs a directed table (8421 defaults, digit count limits, bad nibbles,
// degenerate weights) and then randomized phases with new weights and
// digit counts. Every output beat is compared in order against a table
// value or a local model of the greedy digit coder. Both stream sides idle
// at random; the output side holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module tb_weighted_bcd_codec_top;

    import wbcd_pkg::*;

    localparam logic        CMD_ENCODE   = 1'b0;
    localparam logic        CMD_DECODE   = 1'b1;
    localparam logic [2:0]  REG_UNUSED   = 3'd7;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_BEATS  = 115;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned IDLE_PERCENT = 14;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DEC_WEIGHT [4] = '{1, 10, 100, 1000};
    // weight sets, code bit 3 in the top nibble
    localparam logic [15:0] SCHEMES [7] = '{16'h8421, 16'h2421, 16'h5421, 16'h5211,
                                            16'h4221, 16'h7421, 16'h3321};

    typedef struct {
        logic [15:0] result;
        logic        error;
        logic        cmd;
        logic [15:0] operand;
    } codec_result_t;

    typedef struct {
        bit          is_write;
        logic [2:0]  index;
        logic [3:0]  value;
        logic        cmd;
        logic [15:0] operand;
        bit          typed;
        logic [15:0] result;
        logic        error;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] operand
    logic        s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] result
    logic        m_tuser;   // [0] error
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [3:0]  cfg_wdata;

    // local copy of the configuration, code_weight[k] weighs code bit k
    logic [3:0]    code_weight [4];
    logic [2:0]    digit_limit;

    codec_result_t pending_results [$];
    stim_row_t     directed_rows [$];
    int unsigned   fault_count;
    bit            calm;
    bit            hold_req;
    int unsigned   hold_left;

    weighted_bcd_codec_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [3:0] greedy_code(input int unsigned digit);
        int unsigned rem;
        logic [3:0]  code;
        rem  = digit;
        code = '0;
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= code_weight[k])
            begin
                rem     = rem - code_weight[k];
                code[k] = 1'b1;
            end
        end
        return code;
    endfunction

    function automatic int unsigned active_digits();
        return (digit_limit > MAX_DIGITS) ? MAX_DIGITS : digit_limit;
    endfunction

    function automatic codec_result_t codec_convert(input logic cmd, input logic [15:0] opnd);
        codec_result_t r;
        int unsigned   n;
        int unsigned   acc;
        int unsigned   code32;
        logic [3:0]    nib;
        bit            hit;
        n         = active_digits();
        acc       = 0;
        r.error   = 1'b0;
        r.cmd     = cmd;
        r.operand = opnd;
        if (cmd == CMD_ENCODE)
        begin
            for (int i = 0; i < n; i++)
            begin
                code32 = greedy_code((opnd / DEC_WEIGHT[i]) % 10);
                acc    = acc | (code32 << (4 * i));
            end
        end
        else
        begin
            for (int i = 0; i < n && !r.error; i++)
            begin
                nib = opnd[4 * i +: 4];
                hit = 1'b0;
                // duplicate codes all count
                for (int j = 0; j < 10; j++)
                begin
                    if (greedy_code(j) == nib)
                    begin
                        acc = acc + j * DEC_WEIGHT[i];
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    acc     = 0;
                    r.error = 1'b1;
                end
            end
        end
        r.result = acc[15:0];
        return r;
    endfunction

    function automatic void add_beat(input logic cmd, input logic [15:0] opnd, input bit typed,
                                     input logic [15:0] res, input logic err);
        stim_row_t row;
        row          = '{default: '0};
        row.cmd      = cmd;
        row.operand  = opnd;
        row.typed    = typed;
        row.result   = res;
        row.error    = err;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [2:0] idx, input logic [3:0] val);
        stim_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.index    = idx;
        row.value    = val;
        directed_rows.push_back(row);
    endfunction

    // drop valid and wait for every pending result
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_WEIGHT_MSB:    code_weight[3] = val;
            REG_WEIGHT_SECOND: code_weight[2] = val;
            REG_WEIGHT_THIRD:  code_weight[1] = val;
            REG_WEIGHT_LSB:    code_weight[0] = val;
            REG_DIGIT_COUNT:   digit_limit    = val[2:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_beat(input logic cmd, input logic [15:0] opnd, input bit typed,
                             input logic [15:0] res, input logic err);
        codec_result_t exp;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= opnd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp = codec_convert(cmd, opnd);
        if (typed)
        begin
            exp.result = res;
            exp.error  = err;
        end
        pending_results.push_back(exp);
    endtask

    // output side: random idling, plus a long hold-off on request
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left  = hold_left - 1;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        codec_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result beat: result %h error %0d", m_tdata, m_tuser);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (m_tdata !== exp.result || m_tuser !== exp.error)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch cmd %0d operand %h: result exp %h got %h, error exp %0d got %0d",
                                 exp.cmd, exp.operand, exp.result, m_tdata, exp.error, m_tuser);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] scheme;
        logic [2:0]  count;
        logic [3:0]  count_word;
        logic [15:0] opnd;
        logic        cmd;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_ENCODE;
        cfg_wen        = 1'b0;
        cfg_index      = REG_WEIGHT_MSB;
        cfg_wdata      = '0;
        fault_count    = 0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        code_weight[3] = 4'd8;
        code_weight[2] = 4'd4;
        code_weight[1] = 4'd2;
        code_weight[0] = 4'd1;
        digit_limit    = 3'd3;

        // defaults after reset: 8421, three digits
        add_beat(CMD_ENCODE, 16'd0,     1, 16'h0000, 1'b0);
        add_beat(CMD_ENCODE, 16'hFFFF,  1, 16'h0535, 1'b0);
        add_beat(CMD_ENCODE, 16'd999,   1, 16'h0999, 1'b0);
        add_beat(CMD_ENCODE, 16'd1000,  1, 16'h0000, 1'b0);
        add_beat(CMD_DECODE, 16'h0999,  1, 16'd999,  1'b0);
        add_beat(CMD_DECODE, 16'h0000,  1, 16'd0,    1'b0);
        add_beat(CMD_DECODE, 16'h000A,  1, 16'd0,    1'b1);
        add_beat(CMD_DECODE, 16'hFFFF,  1, 16'd0,    1'b1);
        add_beat(CMD_DECODE, 16'hF123,  1, 16'd123,  1'b0);
        add_beat(CMD_DECODE, 16'h0A12,  1, 16'd0,    1'b1);
        add_write(REG_DIGIT_COUNT, 4'd4);
        add_beat(CMD_ENCODE, 16'hFFFF,  1, 16'h5535, 1'b0);
        add_beat(CMD_DECODE, 16'h9999,  1, 16'd9999, 1'b0);
        // count above the digit limit saturates
        add_write(REG_DIGIT_COUNT, 4'd7);
        add_beat(CMD_ENCODE, 16'd12345, 1, 16'h2345, 1'b0);
        add_beat(CMD_DECODE, 16'h1234,  1, 16'd1234, 1'b0);
        add_write(REG_DIGIT_COUNT, 4'd0);
        add_beat(CMD_ENCODE, 16'hFFFF,  1, 16'h0000, 1'b0);
        add_beat(CMD_DECODE, 16'hFFFF,  1, 16'd0,    1'b0);
        add_write(REG_DIGIT_COUNT, 4'd1);
        add_beat(CMD_ENCODE, 16'd7,     1, 16'h0007, 1'b0);
        add_beat(CMD_DECODE, 16'hFFF5,  1, 16'd5,    1'b0);
        // index outside the register map changes nothing
        add_write(REG_UNUSED, 4'hF);
        add_write(REG_DIGIT_COUNT, 4'd3);
        add_write(REG_WEIGHT_MSB, 4'd2);
        add_beat(CMD_ENCODE, 16'd9876,  0, 16'h0000, 1'b0);
        add_beat(CMD_DECODE, 16'h0FFF,  0, 16'h0000, 1'b0);
        // zero weights: every digit codes to all ones
        add_write(REG_WEIGHT_MSB, 4'd0);
        add_write(REG_WEIGHT_SECOND, 4'd0);
        add_write(REG_WEIGHT_THIRD, 4'd0);
        add_write(REG_WEIGHT_LSB, 4'd0);
        add_beat(CMD_DECODE, 16'h0FFF,  0, 16'h0000, 1'b0);
        add_beat(CMD_DECODE, 16'h0000,  0, 16'h0000, 1'b0);
        add_beat(CMD_ENCODE, 16'hFFFF,  0, 16'h0000, 1'b0);
        // full weights: no digit reaches any weight
        add_write(REG_WEIGHT_MSB, 4'd15);
        add_write(REG_WEIGHT_SECOND, 4'd15);
        add_write(REG_WEIGHT_THIRD, 4'd15);
        add_write(REG_WEIGHT_LSB, 4'd15);
        add_beat(CMD_DECODE, 16'h0000,  0, 16'h0000, 1'b0);
        add_beat(CMD_ENCODE, 16'd12345, 0, 16'h0000, 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_write)
            begin
                settle();
                write_reg(directed_rows[r].index, directed_rows[r].value);
            end
            else
                send_beat(directed_rows[r].cmd, directed_rows[r].operand,
                          directed_rows[r].typed, directed_rows[r].result,
                          directed_rows[r].error);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == 0)
            begin
                scheme = 16'h8421;
                count  = 3'd3;
            end
            else if (phase == 1 || phase == 2)
            begin
                scheme = SCHEMES[$urandom_range(0, 6)];
                count  = (phase == 1) ? 3'd4 : 3'd1;
            end
            else
            begin
                scheme = ($urandom_range(0, 9) < 3) ? 16'($urandom)
                                                    : SCHEMES[$urandom_range(0, 6)];
                count  = ($urandom_range(0, 9) < 2) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4));
            end
            count_word = {1'($urandom_range(0, 1)), count};
            write_reg(REG_WEIGHT_MSB,    scheme[15:12]);
            write_reg(REG_WEIGHT_SECOND, scheme[11:8]);
            write_reg(REG_WEIGHT_THIRD,  scheme[7:4]);
            write_reg(REG_WEIGHT_LSB,    scheme[3:0]);
            write_reg(REG_DIGIT_COUNT,   count_word);
            calm = (phase == 4);

            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (k == 30 && (phase == 3 || phase == 7))
                    hold_req = 1'b1;
                opnd = 16'($urandom);
                cmd  = ($urandom_range(0, 99) < 45) ? CMD_ENCODE : CMD_DECODE;
                if (cmd == CMD_ENCODE && $urandom_range(0, 1))
                    opnd = 16'($urandom_range(0, 9999));
                else if (cmd == CMD_DECODE && $urandom_range(0, 99) < 75)
                begin
                    // valid codes in the active nibbles, noise above
                    for (int i = 0; i < active_digits(); i++)
                        opnd[4 * i +: 4] = greedy_code($urandom_range(0, 9));
                end
                send_beat(cmd, opnd, 0, 16'h0000, 1'b0);
            end
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/wbcd_pkg.sv
src/weighted_bcd_codec_top.sv
tb/tb_weighted_bcd_codec_top.sv
